FILE: rtl/core/headset_jack_and_button_detector_core_macros.svh
// Assertion macros used by the headset jack and button detector state RTL.
`ifndef HEADSET_JACK_AND_BUTTON_DETECTOR_CORE_MACROS_SVH
`define HEADSET_JACK_AND_BUTTON_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HJBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hjbd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HJBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hjbd check failed");

`endif

FILE: rtl/core/hjbd_pkg.sv
// Types and constants of the headset jack and button detector.
package hjbd_pkg;

    localparam int BTN_COUNT   = 4;
    localparam int NUM_THR     = BTN_COUNT + 1;
    localparam int MV_W        = 12;
    localparam int KEY_W       = 3;
    localparam int HELD_W      = BTN_COUNT;
    localparam int CFG_ADDR_W  = 3;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    localparam logic [KEY_W-1:0] KEY_NONE = 3'd4;

    localparam logic [1:0] KIND_NONE      = 2'd0;
    localparam logic [1:0] KIND_HEADPHONE = 2'd1;
    localparam logic [1:0] KIND_HEADSET   = 2'd2;

    localparam logic [1:0] AB_HEADPHONE = 2'd0;
    localparam logic [1:0] AB_HEADSET   = 2'd1;
    localparam logic [1:0] AB_INVALID   = 2'd2;
    localparam logic [1:0] AB_PLUGOUT   = 2'd3;

    localparam logic OP_JACK_PIN = 1'b0;
    localparam logic OP_DETECTOR = 1'b1;

    typedef struct packed {
        logic            op;
        logic            jack_pin;
        logic            uart_pin;
        logic [1:0]      ab_status;
        logic [MV_W-1:0] button_mv;
    } t_event;

    typedef struct packed {
        logic              report_valid;
        logic [1:0]        jack_kind;
        logic [HELD_W-1:0] buttons_held;
    } t_result;

endpackage

FILE: rtl/core/hjbd_classifier.sv
// Threshold register bank and button voltage classifier.
module hjbd_classifier (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hjbd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [hjbd_pkg::MV_W-1:0]        i_cfg_wdata,
    input  logic [hjbd_pkg::MV_W-1:0]        i_mv,
    output logic [hjbd_pkg::KEY_W-1:0]       o_key
);
    import hjbd_pkg::*;

    logic [MV_W-1:0] r_thr [NUM_THR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THR; i++) begin
                r_thr[i] <= '0;
            end
        end else if (i_cfg_we && (32'(i_cfg_addr) < NUM_THR)) begin
            r_thr[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // Scan bands upward so the highest matching band wins; an empty band never matches.
    always_comb begin
        o_key = KEY_NONE;
        for (int i = 0; i < BTN_COUNT; i++) begin
            if ((i_mv < r_thr[i+1]) && (i_mv >= r_thr[i])) begin
                o_key = KEY_W'(i);
            end
        end
    end

endmodule

FILE: rtl/core/hjbd_state.sv
// Jack and button state update with the registered result.
`include "headset_jack_and_button_detector_core_macros.svh"

module hjbd_state (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  hjbd_pkg::t_event           i_ev,
    input  logic [hjbd_pkg::KEY_W-1:0] i_key,
    output hjbd_pkg::t_result          o_res
);
    import hjbd_pkg::*;

    logic              r_present, n_present;
    logic [1:0]        r_kind, n_kind;
    logic              r_en, n_en;
    logic [HELD_W-1:0] r_held, n_held;
    logic [KEY_W-1:0]  r_last, n_last;
    logic              n_report;
    t_result           r_res, n_res;

    always_comb begin
        n_present = r_present;
        n_kind    = r_kind;
        n_en      = r_en;
        n_held    = r_held;
        n_last    = r_last;
        n_report  = 1'b0;
        if (i_ev.op == OP_JACK_PIN) begin
            if (!i_ev.jack_pin) begin
                n_present = 1'b1;
            end else begin
                n_kind    = KIND_NONE;
                n_en      = 1'b0;
                n_held    = '0;
                n_present = 1'b0;
                n_report  = 1'b1;
            end
        end else begin
            if (!i_ev.uart_pin || i_ev.jack_pin) begin
                n_kind    = KIND_NONE;
                n_en      = 1'b0;
                n_held    = '0;
                n_present = 1'b0;
                n_report  = 1'b1;
            end else begin
                if (r_en) begin
                    // release drops the last key's bit, a press from no key sets it
                    if ((i_key == KEY_NONE) && (r_last != KEY_NONE)) begin
                        n_held = r_held & ~(HELD_W'(1) << r_last[1:0]);
                    end else if ((r_last == KEY_NONE) && (i_key != KEY_NONE)) begin
                        n_held = r_held | (HELD_W'(1) << i_key[1:0]);
                    end
                    n_last = i_key;
                end else begin
                    unique case (i_ev.ab_status)
                        AB_PLUGOUT: begin
                            if ((r_kind != KIND_NONE) || !r_present) begin
                                n_kind = KIND_NONE;
                                n_held = '0;
                                n_en   = 1'b0;
                            end
                        end
                        AB_HEADPHONE: begin
                            if ((r_kind == KIND_NONE) && r_present) begin
                                n_kind = KIND_HEADPHONE;
                            end
                        end
                        AB_HEADSET: begin
                            if ((r_kind == KIND_NONE) && r_present) begin
                                n_kind = KIND_HEADSET;
                                n_en   = 1'b1;
                                n_held = '0;
                            end
                        end
                        AB_INVALID: begin
                        end
                    endcase
                end
                n_report = r_present;
            end
        end
        n_res.report_valid = n_report;
        n_res.jack_kind    = n_report ? n_kind : KIND_NONE;
        n_res.buttons_held = n_report ? n_held : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
            r_kind    <= KIND_NONE;
            r_en      <= 1'b0;
            r_held    <= '0;
            r_last    <= KEY_NONE;
        end else if (i_load) begin
            r_present <= n_present;
            r_kind    <= n_kind;
            r_en      <= n_en;
            r_held    <= n_held;
            r_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

    `HJBD_ASSERT_IMP(a_held_needs_buttons, i_clk, i_rst_n, r_held != '0, r_en)
    `HJBD_ASSERT_IMP(a_buttons_need_headset, i_clk, i_rst_n, r_en, r_kind == KIND_HEADSET)
    `HJBD_ASSERT_IMP(a_kind_needs_jack, i_clk, i_rst_n, r_kind != KIND_NONE, r_present)
    `HJBD_ASSERT_NEXT(a_insert_sets_jack, i_clk, i_rst_n,
        i_load && (i_ev.op == OP_JACK_PIN) && !i_ev.jack_pin, r_present)

endmodule

FILE: rtl/core/headset_jack_and_button_detector_core.sv
// Top level of the headset jack and button detector: stream ports and pipeline control.
// An accepted input beat reaches the master side through the input and result registers.
// Throughput: one beat per cycle while the master side does not stall; the input register
// and the result register form a two-stage pipeline, and the single state update per beat sets the rate.
// Reset (synchronous, active low) clears thresholds, jack state and both valid flags;
// last_key resets to no key.
module headset_jack_and_button_detector_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port: index 0..4 selects threshold_0..threshold_4
    input  logic                             i_cfg_we,
    input  logic [hjbd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [hjbd_pkg::MV_W-1:0]        i_cfg_wdata,
    // event stream in
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [hjbd_pkg::S_TDATA_W-1:0]   i_s_tdata,  // jack_pin, uart_pin, ab_status[1:0], button_mv[11:0]
    input  logic                             i_s_tuser,  // operation
    // report stream out
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [hjbd_pkg::M_TDATA_W-1:0]   o_m_tdata,  // jack_kind[1:0], buttons_held[3:0], zero pad
    output logic                             o_m_tuser   // report_valid
);
    import hjbd_pkg::*;

    logic             r_in_valid;
    t_event           r_ev;
    logic             r_out_valid;
    logic             w_adv;
    logic [KEY_W-1:0] w_key;
    t_result          w_res;

    // Advance the input stage whenever the result register is free or being drained.
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the beat payload; hold it while the stage is stalled.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_ev.op        <= i_s_tuser;
            r_ev.jack_pin  <= i_s_tdata[0];
            r_ev.uart_pin  <= i_s_tdata[1];
            r_ev.ab_status <= i_s_tdata[3:2];
            r_ev.button_mv <= i_s_tdata[15:4];
        end
    end

    hjbd_classifier u_classifier (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_mv        (r_ev.button_mv),
        .o_key       (w_key)
    );

    hjbd_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv),
        .i_ev    (r_ev),
        .i_key   (w_key),
        .o_res   (w_res)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = w_res.report_valid;
    assign o_m_tdata  = {(M_TDATA_W - HELD_W - 2)'(0), w_res.buttons_held, w_res.jack_kind};

endmodule
